/* hw/rtl/lpp_pkg.sv */
package lpp_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int ANGLE_W  = 21;
    localparam int SUM_W    = 25;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_ANGLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE    = 8'd1;

    localparam logic [WORD_W-1:0] RING_SIZE_RESET = 16'd360;

    localparam logic [BYTE_W-1:0] HEADER [4] = '{8'h55, 8'hAA, 8'h03, 8'h08};

    localparam logic signed [16:0] ANGLE_ZERO = 17'sh0A000;

    localparam logic signed [SUM_W-1:0] ANGLE_MAX = 25'sd1048575;
    localparam logic signed [SUM_W-1:0] ANGLE_MIN = -25'sd1048576;

    typedef struct packed {
        logic [WORD_W-1:0] speed;
        logic [WORD_W-1:0] start;
        logic [WORD_W-1:0] stop;
    } lpp_words_t;

    typedef struct packed {
        logic valid;
        logic full;
    } lpp_qstat_t;

    function automatic logic [ANGLE_W-1:0] clamp_angle(input logic signed [SUM_W-1:0] v);
        logic [ANGLE_W-1:0] r;
        if (v > ANGLE_MAX) begin
            r = ANGLE_MAX[ANGLE_W-1:0];
        end else if (v < ANGLE_MIN) begin
            r = ANGLE_MIN[ANGLE_W-1:0];
        end else begin
            r = v[ANGLE_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/lpp_front.sv */
module lpp_front
    import lpp_pkg::*;
#(
    parameter int POINTS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   byte_valid,
    input  logic [BYTE_W-1:0]      rx_byte,
    output logic                   push,
    output lpp_words_t             push_words,
    output logic [POINTS*16-1:0]   push_dist,
    output logic [POINTS*8-1:0]    push_inten
);

    localparam int PAYLOAD_BYTES = 8 + 3 * POINTS;
    localparam int END_OFFSET    = 4 + 3 * POINTS;
    localparam int PW            = (POINTS > 1) ? $clog2(POINTS) : 1;

    logic [1:0]        sync_reg;
    logic              in_payload_reg;
    logic [5:0]        count_reg;
    logic [PW-1:0]     pt_reg;
    logic [1:0]        part_reg;
    logic [WORD_W-1:0] speed_reg;
    logic [WORD_W-1:0] start_reg;
    logic [WORD_W-1:0] end_reg;
    logic [WORD_W-1:0] dist_reg  [POINTS];
    logic [BYTE_W-1:0] inten_reg [POINTS];

    logic in_points;
    logic last_byte;

    assign in_points = (count_reg >= 6'd4) && (count_reg < 6'(END_OFFSET));
    assign last_byte = (count_reg == 6'(PAYLOAD_BYTES - 1));
    assign push      = byte_valid && in_payload_reg && last_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg       <= 2'd0;
            in_payload_reg <= 1'b0;
            count_reg      <= 6'd0;
            pt_reg         <= '0;
            part_reg       <= 2'd0;
        end else if (byte_valid) begin
            if (!in_payload_reg) begin
                if (rx_byte == HEADER[sync_reg]) begin
                    if (sync_reg == 2'd3) begin
                        sync_reg       <= 2'd0;
                        in_payload_reg <= 1'b1;
                        count_reg      <= 6'd0;
                        pt_reg         <= '0;
                        part_reg       <= 2'd0;
                    end else begin
                        sync_reg <= sync_reg + 2'd1;
                    end
                end else begin
                    sync_reg <= 2'd0;
                end
            end else begin
                if (last_byte) begin
                    in_payload_reg <= 1'b0;
                    count_reg      <= 6'd0;
                end else begin
                    count_reg <= count_reg + 6'd1;
                end
                if (in_points) begin
                    if (part_reg == 2'd2) begin
                        part_reg <= 2'd0;
                        pt_reg   <= pt_reg + PW'(1);
                    end else begin
                        part_reg <= part_reg + 2'd1;
                    end
                end
            end
        end
    end

    // packet data, no reset needed
    always_ff @(posedge aclk) begin
        if (byte_valid && in_payload_reg) begin
            priority if (count_reg == 6'd0) begin
                speed_reg[7:0] <= rx_byte;
            end else if (count_reg == 6'd1) begin
                speed_reg[15:8] <= rx_byte;
            end else if (count_reg == 6'd2) begin
                start_reg[7:0] <= rx_byte;
            end else if (count_reg == 6'd3) begin
                start_reg[15:8] <= rx_byte;
            end else if (in_points) begin
                if (part_reg == 2'd0) begin
                    dist_reg[pt_reg][7:0] <= rx_byte;
                end else if (part_reg == 2'd1) begin
                    dist_reg[pt_reg][15:8] <= rx_byte;
                end else begin
                    inten_reg[pt_reg] <= rx_byte;
                end
            end else if (count_reg == 6'(END_OFFSET)) begin
                end_reg[7:0] <= rx_byte;
            end else if (count_reg == 6'(END_OFFSET + 1)) begin
                end_reg[15:8] <= rx_byte;
            end
        end
    end

    assign push_words.speed = speed_reg;
    assign push_words.start = start_reg;
    assign push_words.stop  = end_reg;

    for (genvar i = 0; i < POINTS; i++) begin : g_flat
        assign push_dist[i*16 +: 16] = dist_reg[i];
        assign push_inten[i*8 +: 8]  = inten_reg[i];
    end

endmodule

/* hw/rtl/lpp_queue.sv */
module lpp_queue
    import lpp_pkg::*;
#(
    parameter int DATA_W = 240
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output lpp_qstat_t        status,
    output logic [DATA_W-1:0] head_data
);

    logic [1:0]        count_reg;
    logic [DATA_W-1:0] slot0_reg;
    logic [DATA_W-1:0] slot1_reg;

    assign status.valid = (count_reg != 2'd0);
    assign status.full  = (count_reg == 2'd2);
    assign head_data    = slot0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case ({push, pop})
            2'b10: begin
                if (count_reg == 2'd0) begin
                    slot0_reg <= push_data;
                end else begin
                    slot1_reg <= push_data;
                end
            end
            2'b01: begin
                slot0_reg <= slot1_reg;
            end
            2'b11: begin
                if (count_reg == 2'd1) begin
                    slot0_reg <= push_data;
                end else begin
                    slot0_reg <= slot1_reg;
                    slot1_reg <= push_data;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* hw/rtl/lpp_back.sv */
module lpp_back
    import lpp_pkg::*;
#(
    parameter int POINTS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      head_valid,
    input  lpp_words_t                head_words,
    input  logic [POINTS*16-1:0]      head_dist,
    input  logic [POINTS*8-1:0]       head_inten,
    output logic                      pop,
    input  logic                      invert_angle,
    input  logic [WORD_W-1:0]         ring_size,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [ANGLE_W-1:0] m_point_angle,
    output logic [WORD_W-1:0]         m_point_distance,
    output logic [BYTE_W-1:0]         m_point_intensity,
    output logic [WORD_W-1:0]         m_ring_slot,
    output logic [WORD_W-1:0]         m_speed_raw,
    output logic                      m_last_of_packet
);

    localparam int PW    = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int LOGN  = (POINTS > 1) ? $clog2(POINTS) : 0;
    localparam int MAG_W = 23;
    localparam int ACC_W = MAG_W + 1;
    localparam int SHIFT = MAG_W + LOGN;
    localparam int MW    = SHIFT + 1;
    localparam int PR_W  = MAG_W + MW;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SHIFT) + 64'(POINTS) - 64'd1) / 64'(POINTS));

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ABS  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]              state_reg;
    logic [PW-1:0]           idx_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic [PR_W-1:0]         prod_reg;
    logic                    neg2_reg;
    logic [WORD_W-1:0]       write_slot_reg;
    logic                    m_valid_reg;

    logic signed [16:0]        start_off;
    logic signed [16:0]        diff;
    logic signed [19:0]        base_w;
    logic signed [19:0]        span_w;
    logic signed [ACC_W-1:0]   acc_neg;
    logic [MAG_W-1:0]          quot;
    logic signed [SUM_W-1:0]   quot_s;
    logic signed [SUM_W-1:0]   sum;
    logic [ANGLE_W-1:0]        clamped;
    logic signed [SUM_W-1:0]   negated;
    logic [ANGLE_W-1:0]        angle;
    logic [WORD_W-1:0]         slot;
    logic [WORD_W:0]           slot_inc;
    logic [WORD_W-1:0]         write_slot_next;
    logic                      last_pt;
    logic                      out_load;

    assign start_off = $signed({1'b0, head_words.start}) - ANGLE_ZERO;
    assign diff      = $signed({1'b0, head_words.stop}) - $signed({1'b0, head_words.start});
    assign base_w    = {start_off, 3'b000};
    assign span_w    = {diff, 3'b000};
    assign acc_neg   = -acc_reg;

    assign quot    = prod_reg[SHIFT +: MAG_W];
    assign quot_s  = neg2_reg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    assign sum     = $signed({{(SUM_W-20){base_w[19]}}, base_w}) + quot_s;
    assign clamped = clamp_angle(sum);
    assign negated = -$signed({{(SUM_W-ANGLE_W){clamped[ANGLE_W-1]}}, clamped});
    assign angle   = invert_angle ? clamp_angle(negated) : clamped;

    assign slot            = (write_slot_reg < ring_size) ? write_slot_reg : '0;
    assign slot_inc        = {1'b0, slot} + 17'd1;
    assign write_slot_next = (slot_inc >= {1'b0, ring_size}) ? '0 : slot_inc[WORD_W-1:0];

    assign last_pt  = (idx_reg == PW'(POINTS - 1));
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign pop      = out_load && last_pt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            write_slot_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (head_valid) begin
                        idx_reg   <= '0;
                        state_reg <= ST_ABS;
                    end
                end
                ST_ABS: begin
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        if (last_pt) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + PW'(1);
                            state_reg <= ST_ABS;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (out_load) begin
                write_slot_reg <= write_slot_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // angle datapath: running span sum, magnitude, reciprocal multiply, output register load
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            acc_reg <= '0;
        end else if (out_load && !last_pt) begin
            acc_reg <= acc_reg + $signed({{(ACC_W-20){span_w[19]}}, span_w});
        end
        if (state_reg == ST_ABS) begin
            mag_reg <= acc_reg[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_reg[MAG_W-1:0];
            neg_reg <= acc_reg[ACC_W-1];
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= {{MW{1'b0}}, mag_reg} * {{MAG_W{1'b0}}, RECIP};
            neg2_reg <= neg_reg;
        end
        if (out_load) begin
            m_point_angle     <= angle;
            m_point_distance  <= head_dist[idx_reg*16 +: 16];
            m_point_intensity <= head_inten[idx_reg*8 +: 8];
            m_ring_slot       <= slot;
            m_speed_raw       <= head_words.speed;
            m_last_of_packet  <= last_pt;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* hw/rtl/lidar_packet_parser_top.sv */
// Scan packet parser. Bytes from the sensor link enter on the s_ channel, one per
// transfer; the parser hunts for the 55 AA 03 08 header, collects speed, start angle,
// the points and end angle, skips the checksum (not checked), and queues each
// finished packet. Input bytes are taken one per cycle and stall only while two
// finished packets already wait in the queue. The output side handles one point at
// a time, by magnitude, reciprocal multiply, then rounding/clamp into the output
// register, and holds in the last step while an output waits on m_ready.
// Angles are in 1/512 degree, interpolated between start and end angle and negated
// when invert_angle is set. Config registers: index 0 invert_angle, index 1 ring_size
// (reset 360); other indices are ignored. Write them only while the block is idle.
module lidar_packet_parser_top
    import lpp_pkg::*;
#(
    parameter int POINTS_PER_PACKET = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [BYTE_W-1:0]         s_rx_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [ANGLE_W-1:0] m_point_angle,
    output logic [WORD_W-1:0]         m_point_distance,
    output logic [BYTE_W-1:0]         m_point_intensity,
    output logic [WORD_W-1:0]         m_ring_slot,
    output logic [WORD_W-1:0]         m_speed_raw,
    output logic                      m_last_of_packet,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [WORD_W-1:0]         cfg_data
);

    localparam int N      = POINTS_PER_PACKET;
    localparam int DIST_W = N * 16;
    localparam int INT_W  = N * 8;
    localparam int DATA_W = 3 * WORD_W + DIST_W + INT_W;

    logic              invert_reg;
    logic [WORD_W-1:0] ring_size_reg;

    logic              byte_xfer;
    logic              q_push;
    logic              q_pop;
    lpp_qstat_t        q_stat;
    lpp_words_t        push_words;
    lpp_words_t        head_words;
    logic [DIST_W-1:0] push_dist;
    logic [INT_W-1:0]  push_inten;
    logic [DATA_W-1:0] push_data;
    logic [DATA_W-1:0] head_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_reg    <= 1'b0;
            ring_size_reg <= RING_SIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_INVERT_ANGLE: invert_reg    <= cfg_data[0];
                CFG_RING_SIZE:    ring_size_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign s_ready   = !q_stat.full;
    assign byte_xfer = s_valid && s_ready;

    lpp_front #(
        .POINTS(N)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_valid(byte_xfer),
        .rx_byte   (s_rx_byte),
        .push      (q_push),
        .push_words(push_words),
        .push_dist (push_dist),
        .push_inten(push_inten)
    );

    assign push_data = {push_words, push_dist, push_inten};

    lpp_queue #(
        .DATA_W(DATA_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(push_data),
        .pop      (q_pop),
        .status   (q_stat),
        .head_data(head_data)
    );

    assign head_words = head_data[DATA_W-1 -: 3*WORD_W];

    lpp_back #(
        .POINTS(N)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (q_stat.valid),
        .head_words       (head_words),
        .head_dist        (head_data[INT_W +: DIST_W]),
        .head_inten       (head_data[INT_W-1:0]),
        .pop              (q_pop),
        .invert_angle     (invert_reg),
        .ring_size        (ring_size_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_point_angle    (m_point_angle),
        .m_point_distance (m_point_distance),
        .m_point_intensity(m_point_intensity),
        .m_ring_slot      (m_ring_slot),
        .m_speed_raw      (m_speed_raw),
        .m_last_of_packet (m_last_of_packet)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_stat.full))
        else $error("packet queue overflow");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_stat.valid)
        else $error("pop from empty packet queue");

    a_ring_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready && cfg_index == CFG_RING_SIZE) |=>
            ring_size_reg == $past(cfg_data))
        else $error("ring size write lost");

endmodule

/* tb/sv/lidar_packet_parser_top_test.sv */
module lidar_packet_parser_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lpp_pkg::*;

    localparam int POINTS        = 8;
    localparam int PAYLOAD_LEN   = 8 + 3 * POINTS;
    localparam int PACKET_LEN    = 4 + PAYLOAD_LEN;
    localparam int STOP_POS      = 4 + 3 * POINTS;
    localparam int RANDOM_ITEMS  = 430;
    localparam int PHASES        = 6;
    localparam int SETTLE_CYCLES = 3 * POINTS + 16;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HIGH = 8'hFF;

    typedef enum int {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE,
        READY_MOSTLY
    } ready_mode_e;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic [WORD_W-1:0]         distance;
        logic [BYTE_W-1:0]         intensity;
        logic [WORD_W-1:0]         slot;
        logic [WORD_W-1:0]         speed;
        logic                      last;
    } point_t;

    class lidar_point_scoreboard;
        bit                 invert_angle;
        bit [WORD_W-1:0]    ring_size;
        bit [1:0]           header_pos;
        bit [5:0]           payload_pos;
        bit                 in_payload;
        bit [WORD_W-1:0]    speed_word;
        bit [WORD_W-1:0]    start_word;
        bit [WORD_W-1:0]    stop_word;
        bit [WORD_W-1:0]    next_slot;
        bit [WORD_W-1:0]    distances [POINTS];
        bit [BYTE_W-1:0]    intensities [POINTS];
        point_t             expected_points [$];
        int                 mismatches;
        int                 points_checked;
        int                 packets_framed;

        function new();
            ring_size = RING_SIZE_RESET;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
            if (idx == CFG_INVERT_ANGLE) begin
                invert_angle = data[0];
            end else if (idx == CFG_RING_SIZE) begin
                ring_size = data;
            end
        endfunction

        function int saturate_angle(int v);
            if (v > ANGLE_MAX) begin
                return ANGLE_MAX;
            end
            if (v < ANGLE_MIN) begin
                return ANGLE_MIN;
            end
            return v;
        endfunction

        function void store_payload(bit [BYTE_W-1:0] b);
            int rel;
            if (payload_pos == 0) begin
                speed_word[7:0] = b;
            end else if (payload_pos == 1) begin
                speed_word[15:8] = b;
            end else if (payload_pos == 2) begin
                start_word[7:0] = b;
            end else if (payload_pos == 3) begin
                start_word[15:8] = b;
            end else if (payload_pos < STOP_POS) begin
                rel = payload_pos - 4;
                case (rel % 3)
                    0: distances[rel / 3][7:0] = b;
                    1: distances[rel / 3][15:8] = b;
                    default: intensities[rel / 3] = b;
                endcase
            end else if (payload_pos == STOP_POS) begin
                stop_word[7:0] = b;
            end else if (payload_pos == STOP_POS + 1) begin
                stop_word[15:8] = b;
            end
        endfunction

        function void emit_packet();
            int     sw;
            int     ew;
            int     base;
            int     span;
            int     a;
            int     cur;
            point_t p;
            sw = start_word;
            ew = stop_word;
            base = (sw - ANGLE_ZERO) * 8;
            span = (ew - sw) * 8;
            packets_framed++;
            for (int i = 0; i < POINTS; i++) begin
                a = saturate_angle(base + (span * i) / POINTS);
                if (invert_angle) begin
                    a = saturate_angle(-a);
                end
                cur = (next_slot < ring_size) ? next_slot : 0;
                p.angle     = a[ANGLE_W-1:0];
                p.distance  = distances[i];
                p.intensity = intensities[i];
                p.slot      = cur[WORD_W-1:0];
                p.speed     = speed_word;
                p.last      = (i == POINTS - 1);
                expected_points.push_back(p);
                cur++;
                if (cur >= ring_size) begin
                    cur = 0;
                end
                next_slot = cur[WORD_W-1:0];
            end
        endfunction

        function void note_byte(bit [BYTE_W-1:0] b);
            if (!in_payload) begin
                if (b == HEADER[header_pos]) begin
                    if (header_pos == 2'd3) begin
                        header_pos  = 0;
                        in_payload  = 1'b1;
                        payload_pos = 0;
                    end else begin
                        header_pos++;
                    end
                end else begin
                    header_pos = 0;
                end
                return;
            end
            store_payload(b);
            if (payload_pos == PAYLOAD_LEN - 1) begin
                in_payload  = 1'b0;
                payload_pos = 0;
                emit_packet();
            end else begin
                payload_pos++;
            end
        endfunction

        function void check_point(point_t got);
            point_t want;
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected point: angle %0d dist %h slot %0d",
                             got.angle, got.distance, got.slot);
                end
                return;
            end
            want = expected_points.pop_front();
            points_checked++;
            if (got.angle !== want.angle || got.distance !== want.distance ||
                got.intensity !== want.intensity || got.slot !== want.slot ||
                got.speed !== want.speed || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("point %0d mismatch (expected/actual): angle %0d/%0d dist %h/%h",
                             points_checked, want.angle, got.angle, want.distance,
                             got.distance);
                    $display("    intensity %h/%h slot %0d/%0d speed %h/%h last %b/%b",
                             want.intensity, got.intensity, want.slot, got.slot,
                             want.speed, got.speed, want.last, got.last);
                end
            end
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [BYTE_W-1:0]         s_rx_byte = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [ANGLE_W-1:0] m_point_angle;
    logic [WORD_W-1:0]         m_point_distance;
    logic [BYTE_W-1:0]         m_point_intensity;
    logic [WORD_W-1:0]         m_ring_slot;
    logic [WORD_W-1:0]         m_speed_raw;
    logic                      m_last_of_packet;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [WORD_W-1:0]         cfg_data = '0;

    point_t                    seen_point;
    lidar_point_scoreboard     sb = new();
    int                        burst_left;
    int                        bytes_sent;
    int                        config_writes;

    lidar_packet_parser_top #(
        .POINTS_PER_PACKET(POINTS)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_point_angle    (m_point_angle),
        .m_point_distance (m_point_distance),
        .m_point_intensity(m_point_intensity),
        .m_ring_slot      (m_ring_slot),
        .m_speed_raw      (m_speed_raw),
        .m_last_of_packet (m_last_of_packet),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    assign seen_point = '{angle: m_point_angle, distance: m_point_distance,
                          intensity: m_point_intensity, slot: m_ring_slot,
                          speed: m_speed_raw, last: m_last_of_packet};

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_point(seen_point);
        end
    end

    initial begin : ready_pattern
        ready_mode_e mode;
        int          run;
        forever begin
            mode = ready_mode_e'($urandom_range(0, 3));
            run = $urandom_range(1, 40);
            repeat (run) begin
                @(posedge aclk);
                case (mode)
                    READY_ALWAYS: m_ready <= 1'b1;
                    READY_HALF:   m_ready <= ($urandom_range(0, 1) == 1);
                    READY_SPARSE: m_ready <= ($urandom_range(0, 4) == 0);
                    default:      m_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 24);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.note_config(idx, data);
        config_writes++;
    endtask

    // unused indexes carry data that would break the run if they landed anywhere
    task automatic set_mode(input logic inv, input logic [WORD_W-1:0] ring);
        write_reg(CFG_UNUSED_LOW, 16'($urandom));
        write_reg(CFG_RING_SIZE, ring);
        write_reg(CFG_UNUSED_HIGH, 16'h0000);
        write_reg(CFG_INVERT_ANGLE, {15'd0, inv});
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.expected_points.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_packet(input logic [WORD_W-1:0] speed, start_w, stop_w,
                               input logic [WORD_W-1:0] dist_words [POINTS],
                               input logic [BYTE_W-1:0] inten [POINTS]);
        for (int k = 0; k < 4; k++) begin
            send_byte(HEADER[k]);
        end
        send_byte(speed[7:0]);
        send_byte(speed[15:8]);
        send_byte(start_w[7:0]);
        send_byte(start_w[15:8]);
        for (int k = 0; k < POINTS; k++) begin
            send_byte(dist_words[k][7:0]);
            send_byte(dist_words[k][15:8]);
            send_byte(inten[k]);
        end
        send_byte(stop_w[7:0]);
        send_byte(stop_w[15:8]);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_packet();
        logic [WORD_W-1:0] dist_words [POINTS];
        logic [BYTE_W-1:0] inten [POINTS];
        for (int k = 0; k < POINTS; k++) begin
            dist_words[k] = pick_word();
            inten[k] = 8'($urandom);
        end
        send_packet(pick_word(), pick_word(), pick_word(), dist_words, inten);
    endtask

    // header cut short; the bad byte is often a first header byte, which must not restart sync
    task automatic send_broken_header();
        int                k;
        logic [BYTE_W-1:0] wrong;
        k = $urandom_range(1, 3);
        for (int j = 0; j < k; j++) begin
            send_byte(HEADER[j]);
        end
        wrong = ($urandom_range(0, 1) == 0) ? HEADER[0] : 8'($urandom);
        if (wrong == HEADER[k]) begin
            wrong = ~wrong;
        end
        send_byte(wrong);
    endtask

    initial begin : stimulus
        logic [WORD_W-1:0] dist_words [POINTS];
        logic [BYTE_W-1:0] inten [POINTS];
        logic [WORD_W-1:0] ring_plan [PHASES];
        int                phase_start;
        int                phase_bytes;
        ring_plan = '{16'd360, 16'd1, 16'hFFFF, 16'd3,
                      16'($urandom_range(1, 65535)), 16'd13};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // header mismatches, then one packet of extreme values, under the reset settings
        send_byte(HEADER[0]);
        send_byte(HEADER[1]);
        send_byte(HEADER[2]);
        send_byte(HEADER[0]);
        send_byte(HEADER[1]);
        send_byte(HEADER[2]);
        send_byte(HEADER[3]);
        send_byte(HEADER[0]);
        send_byte(HEADER[0]);
        send_byte(HEADER[1]);
        send_byte(HEADER[2]);
        send_byte(HEADER[3]);
        for (int k = 0; k < POINTS; k++) begin
            dist_words[k] = k[0] ? 16'hFFFF : 16'h0000;
            inten[k] = k[0] ? 8'h00 : 8'hFF;
        end
        send_packet(16'hFFFF, 16'h0000, 16'hFFFF, dist_words, inten);
        wait_idle();

        // the last transfer of a phase overshoots by about half a packet on average
        phase_bytes = (RANDOM_ITEMS - bytes_sent) / PHASES - PACKET_LEN / 2;
        for (int ph = 0; ph < PHASES; ph++) begin
            set_mode(ph % 2 == 0, ring_plan[ph]);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < phase_bytes) begin
                case ($urandom_range(0, 9))
                    0: repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
                    1: send_broken_header();
                    default: send_random_packet();
                endcase
            end
            wait_idle();
        end

        $display("sent %0d bytes with %0d register writes, %0d packets framed",
                 bytes_sent, config_writes, sb.packets_framed);
        $display("checked %0d points, %0d mismatches", sb.points_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_points.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
